@@ hw/rtl/htd_pkg.sv @@
// Package: shared types, constants and CORDIC angle table for the haversine trip distance unit.
package htd_pkg;
    localparam int CordicIterations = 32;
    localparam int TripWidth        = 48;
    localparam int IterW            = 6;
    localparam int ChunkW           = 35;

    localparam logic signed [35:0] FullTurn = 36'sd7200000000;
    localparam logic signed [35:0] Quarter  = 36'sd1800000000;
    localparam logic signed [35:0] Eighth   = 36'sd900000000;
    localparam logic [32:0]        RadScale = 33'd4024455254;
    localparam logic signed [63:0] GainInv  = 64'sd652032874;
    localparam logic [63:0]        OneQ60   = 64'h1000_0000_0000_0000;
    localparam logic [12:0]        RadiusKm = 13'd6367;
    localparam logic [12:0]        RadiusMi = 13'd3956;
    localparam logic [TripWidth-1:0] TripMax = '1;

    localparam logic [0:0] ActSample = 1'b0;
    localparam logic [0:0] ActClear  = 1'b1;

    typedef struct packed {
        logic [ChunkW-1:0]    chunk_distance;
        logic [TripWidth-1:0] trip_length;
        logic                 distance_valid;
        logic                 trip_saturated;
    } t_result;

    typedef struct packed {
        logic        action;
        logic [30:0] latitude;
        logic [31:0] longitude;
        logic        fix_valid;
    } t_sample;

    function automatic logic signed [63:0] atan_step(input logic [IterW-1:0] i);
        logic signed [63:0] v;
        case (i)
            6'd0:  v = 64'sd843314856;
            6'd1:  v = 64'sd497837829;
            6'd2:  v = 64'sd263043836;
            6'd3:  v = 64'sd133525158;
            6'd4:  v = 64'sd67021686;
            6'd5:  v = 64'sd33543515;
            6'd6:  v = 64'sd16775850;
            6'd7:  v = 64'sd8388437;
            6'd8:  v = 64'sd4194282;
            6'd9:  v = 64'sd2097149;
            6'd10: v = 64'sd1048575;
            default: begin
                if (i <= 6'd30) begin
                    v = 64'sd1 <<< (6'd30 - i);
                end else begin
                    v = 64'sd0;
                end
            end
        endcase
        return v;
    endfunction
endpackage

@@ hw/rtl/htd_if.sv @@
// Valid/ready channel interfaces for samples and results.
interface htd_sample_if;
    logic             valid;
    logic             ready;
    htd_pkg::t_sample data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface htd_result_if;
    logic             valid;
    logic             ready;
    htd_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/htd_core.sv @@
// Sequenced datapath: angle reduction, shared CORDIC, multiplies, square roots, scaling.
module htd_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_unit_mode,
    input  logic signed [30:0]            i_lat1,
    input  logic signed [31:0]            i_lon1,
    input  logic signed [30:0]            i_lat2,
    input  logic signed [31:0]            i_lon2,
    output logic                          o_done,
    output logic [htd_pkg::ChunkW-1:0]    o_chunk
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RED0  = 5'd1;
    localparam logic [4:0] S_RED1  = 5'd2;
    localparam logic [4:0] S_RED2  = 5'd3;
    localparam logic [4:0] S_ROT   = 5'd4;
    localparam logic [4:0] S_STORE = 5'd5;
    localparam logic [4:0] S_CC    = 5'd6;
    localparam logic [4:0] S_T     = 5'd7;
    localparam logic [4:0] S_SS    = 5'd8;
    localparam logic [4:0] S_TU    = 5'd9;
    localparam logic [4:0] S_A     = 5'd10;
    localparam logic [4:0] S_SQ    = 5'd11;
    localparam logic [4:0] S_VEC   = 5'd12;
    localparam logic [4:0] S_M1    = 5'd13;
    localparam logic [4:0] S_M2    = 5'd14;
    localparam logic [4:0] S_DONE  = 5'd15;
    localparam logic [4:0] S_SEED  = 5'd16;
    localparam int ChunkWL = htd_pkg::ChunkW;

    logic [4:0]  r_state;
    logic [1:0]  r_job;
    logic [5:0]  r_it;
    logic signed [35:0] r_m;
    logic [1:0]  r_k;
    logic signed [63:0] r_x, r_y, r_z;
    logic signed [63:0] r_c1, r_c2, r_s, r_u, r_cc, r_t, r_p;
    logic [63:0] r_v0, r_v1, r_res0, r_res1, r_bit;
    logic [63:0] r_q;
    logic [ChunkWL-1:0] r_chunk;

    logic signed [35:0] w_angle;
    logic signed [63:0] w_dx, w_dy, w_at;
    logic signed [63:0] w_sin, w_cos;
    logic        w_dir;
    logic signed [63:0] w_mul;
    logic signed [31:0] w_ma, w_mb;
    logic [63:0] w_sum0, w_sum1;

    always_comb begin
        case (r_job)
            2'd0:    w_angle = 36'(signed'({i_lat1, 1'b0}));
            2'd1:    w_angle = 36'(signed'({i_lat2, 1'b0}));
            2'd2:    w_angle = 36'(i_lat2) - 36'(i_lat1);
            default: w_angle = 36'(i_lon2) - 36'(i_lon1);
        endcase
    end

    assign w_dx = r_y >>> r_it;
    assign w_dy = r_x >>> r_it;
    assign w_at = htd_pkg::atan_step(r_it);
    assign w_dir = (r_state == S_VEC) ? r_y[63] : !r_z[63];

    always_comb begin
        case (r_k)
            2'd0:    begin w_cos = r_x;  w_sin = r_y;  end
            2'd1:    begin w_cos = -r_y; w_sin = r_x;  end
            2'd2:    begin w_cos = -r_x; w_sin = -r_y; end
            default: begin w_cos = r_y;  w_sin = -r_x; end
        endcase
    end

    always_comb begin
        case (r_state)
            S_CC:    begin w_ma = 32'(r_c1); w_mb = 32'(r_c2); end
            S_T:     begin w_ma = 32'(r_cc); w_mb = 32'(r_u);  end
            S_SS:    begin w_ma = 32'(r_s);  w_mb = 32'(r_s);  end
            S_TU:    begin w_ma = 32'(r_t);  w_mb = 32'(r_u);  end
            default: begin w_ma = signed'(r_q[61:30]);
                           w_mb = i_unit_mode ? 32'(htd_pkg::RadiusMi)
                                              : 32'(htd_pkg::RadiusKm); end
        endcase
    end
    assign w_mul  = 64'(w_ma * w_mb);
    assign w_sum0 = r_res0 + r_bit;
    assign w_sum1 = r_res1 + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_job   <= 2'd0;
                        r_state <= S_RED0;
                    end
                end
                S_RED0: begin
                    // every angle difference stays within one turn
                    r_m <= w_angle;
                    r_state <= S_RED1;
                end
                S_RED1: begin
                    if (r_m < 0) r_m <= r_m + htd_pkg::FullTurn;
                    r_state <= S_RED2;
                end
                S_RED2: begin
                    // quadrant: m in [0, 7.2e9), k from m + eighth against quarter boundaries
                    logic signed [35:0] mm;
                    logic [1:0] kk;
                    logic signed [35:0] rr;
                    logic signed [69:0] pr;
                    mm = r_m + htd_pkg::Eighth;
                    if (mm >= 36'sd5400000000)      kk = 2'd3;
                    else if (mm >= 36'sd3600000000) kk = 2'd2;
                    else if (mm >= htd_pkg::Quarter) kk = 2'd1;
                    else                             kk = 2'd0;
                    if (mm >= 36'sd7200000000) kk = 2'd0;
                    rr = r_m - 36'(kk) * htd_pkg::Quarter
                         - ((mm >= 36'sd7200000000) ? 36'sd7200000000 : 36'sd0);
                    pr = 70'(rr) * 70'(signed'({1'b0, htd_pkg::RadScale})) + 70'sd2147483648;
                    r_k <= kk;
                    r_z <= 64'(pr >>> 32);
                    r_x <= htd_pkg::GainInv;
                    r_y <= '0;
                    r_it <= '0;
                    r_state <= S_ROT;
                end
                S_ROT, S_VEC: begin
                    if (w_dir) begin
                        r_x <= r_x - w_dx; r_y <= r_y + w_dy; r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_dx; r_y <= r_y - w_dy; r_z <= r_z + w_at;
                    end
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'(htd_pkg::CordicIterations - 1)) begin
                        r_state <= (r_state == S_VEC) ? S_M1 : S_STORE;
                    end
                end
                S_STORE: begin
                    case (r_job)
                        2'd0:    r_c1 <= w_cos;
                        2'd1:    r_c2 <= w_cos;
                        2'd2:    r_s  <= w_sin;
                        default: r_u  <= w_sin;
                    endcase
                    r_job <= r_job + 2'd1;
                    r_state <= (r_job == 2'd3) ? S_CC : S_RED0;
                end
                S_CC: begin
                    r_cc <= (w_mul + 64'sd536870912) >>> 30;
                    r_state <= S_T;
                end
                S_T: begin
                    r_t <= (w_mul + 64'sd536870912) >>> 30;
                    r_state <= S_SS;
                end
                S_SS: begin
                    r_p <= w_mul;
                    r_state <= S_TU;
                end
                S_TU: begin
                    r_p <= r_p + w_mul;
                    r_state <= S_A;
                end
                S_A: begin
                    logic [63:0] aa;
                    if (r_p < 0) aa = '0;
                    else if (r_p > signed'(htd_pkg::OneQ60)) aa = htd_pkg::OneQ60;
                    else aa = r_p;
                    r_v0 <= aa;
                    r_v1 <= htd_pkg::OneQ60 - aa;
                    r_res0 <= '0;
                    r_res1 <= '0;
                    r_bit <= 64'h1000_0000_0000_0000;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    // both roots in lockstep; leading bits beyond the value give res 0 steps
                    if (r_v0 >= w_sum0) begin
                        r_v0 <= r_v0 - w_sum0; r_res0 <= (r_res0 >> 1) + r_bit;
                    end else begin
                        r_res0 <= r_res0 >> 1;
                    end
                    if (r_v1 >= w_sum1) begin
                        r_v1 <= r_v1 - w_sum1; r_res1 <= (r_res1 >> 1) + r_bit;
                    end else begin
                        r_res1 <= r_res1 >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    // vectoring starts from (sqrt(1 - a), sqrt(a))
                    r_x <= signed'(r_res1);
                    r_y <= signed'(r_res0);
                    r_z <= '0;
                    r_it <= '0;
                    r_state <= S_VEC;
                end
                S_M1: begin
                    logic [63:0] zz;
                    zz = r_z[63] ? 64'd0 : r_z;
                    r_q <= (zz << 1) * 64'd1000000;
                    r_state <= S_M2;
                end
                S_M2: begin
                    logic [63:0] lo;
                    lo = 64'(r_q[29:0]) * 64'(i_unit_mode ? htd_pkg::RadiusMi
                                                          : htd_pkg::RadiusKm);
                    r_chunk <= ChunkWL'(w_mul + signed'((lo + 64'd536870912) >> 30));
                    r_state <= S_DONE;
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_chunk = r_chunk;
endmodule

@@ hw/rtl/haversine_trip_distance_unit.sv @@
// Top level: haversine trip distance unit with sample/result channels and unit register.
// Usage:
//   i_sample carries one sample (action, latitude, longitude, fix_valid) per transfer.
//   o_result returns exactly one result per sample: chunk and trip distance in
//   millionths of km (unit_mode 0) or miles (unit_mode 1), plus valid/saturated flags.
//   Write i_cfg_we/i_cfg_wdata only while idle; bit 0 selects the radius.
// Sequence:
//   A clear or a sample without a reference: result valid in the cycle after the transfer.
//   A segment sample: result valid once the core finishes: four angle jobs of
//   3 reduction steps, 32 rotation steps and 1 store each, 5 multiply steps, a 31-step
//   dual square root, 1 seed step, 32 vectoring steps, 2 scaling steps, 1 done step.
// Flow:
//   One sample at a time; i_sample.ready is low from acceptance until the
//   result has been transferred.
// Reset:
//   Clears the reference, trip total and unit mode; no result is pending.
// Stall:
//   A result waits in the output register for o_result.ready; no sample is
//   taken until then.
module haversine_trip_distance_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_wdata,
    htd_sample_if.sink   i_sample,
    htd_result_if.source o_result
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  r_state;
    logic        r_unit;
    logic signed [30:0] r_prev_lat, r_cur_lat;
    logic signed [31:0] r_prev_lon, r_cur_lon;
    logic        r_have_ref;
    logic [htd_pkg::TripWidth-1:0] r_trip;
    htd_pkg::t_result r_res;
    logic        w_start, w_done;
    logic [htd_pkg::ChunkW-1:0] w_chunk;
    logic [htd_pkg::TripWidth:0] w_sum;
    logic [htd_pkg::TripWidth-1:0] w_new;

    htd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_unit_mode (r_unit),
        .i_lat1      (r_prev_lat),
        .i_lon1      (r_prev_lon),
        .i_lat2      (r_cur_lat),
        .i_lon2      (r_cur_lon),
        .o_done      (w_done),
        .o_chunk     (w_chunk)
    );

    assign i_sample.ready = (r_state == S_IDLE);
    assign o_result.valid = (r_state == S_OUT);
    assign o_result.data  = r_res;

    assign w_sum = {1'b0, r_trip} + (htd_pkg::TripWidth + 1)'(w_chunk);
    assign w_new = w_sum[htd_pkg::TripWidth] ? htd_pkg::TripMax
                                             : w_sum[htd_pkg::TripWidth-1:0];
    assign w_start = (r_state == S_IDLE) && i_sample.valid
                     && (i_sample.data.action == htd_pkg::ActSample) && r_have_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_unit     <= 1'b0;
            r_have_ref <= 1'b0;
            r_trip     <= '0;
            r_prev_lat <= '0;
            r_prev_lon <= '0;
        end else begin
            if (i_cfg_we) r_unit <= i_cfg_wdata[0];
            case (r_state)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_cur_lat <= i_sample.data.latitude;
                        r_cur_lon <= i_sample.data.longitude;
                        r_res.chunk_distance <= '0;
                        r_res.distance_valid <= 1'b0;
                        if (i_sample.data.action == htd_pkg::ActClear) begin
                            r_have_ref <= 1'b0;
                            r_trip     <= '0;
                            r_prev_lat <= '0;
                            r_prev_lon <= '0;
                            r_res.trip_length    <= '0;
                            r_res.trip_saturated <= 1'b0;
                            r_state <= S_OUT;
                        end else if (!r_have_ref) begin
                            if (i_sample.data.fix_valid) begin
                                r_prev_lat <= i_sample.data.latitude;
                                r_prev_lon <= i_sample.data.longitude;
                                r_have_ref <= 1'b1;
                            end
                            r_res.trip_length    <= r_trip;
                            r_res.trip_saturated <= (r_trip == htd_pkg::TripMax);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_BUSY;
                        end
                    end
                end
                S_BUSY: begin
                    if (w_done) begin
                        r_trip <= w_new;
                        r_prev_lat <= r_cur_lat;
                        r_prev_lon <= r_cur_lon;
                        r_res.chunk_distance <= w_chunk;
                        r_res.distance_valid <= 1'b1;
                        r_res.trip_length    <= w_new;
                        r_res.trip_saturated <= (w_new == htd_pkg::TripMax);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_result.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
